// ===== design/pvs_pkg.sv =====
// Shared types and constants of the polar vector sum block.
// CORDIC word layout, gain constants and the arctangent step table.
// No dependencies.
`default_nettype none

package pvs_pkg;

    // Width of the CORDIC x and y datapath (vectoring input is a 32-bit sum times 16, plus gain)
    localparam int XY_W = 40;
    // Angle width inside the CORDIC, 2^32 units per turn
    localparam int Z_W = 32;

    // CORDIC gain compensation, 1/K in Q30 and in Q26
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [25:0] GAIN_Q26 = 26'd40752055;

    // One word moving down the cell row
    typedef struct packed {
        logic                   vec;   // 1: vectoring, 0: rotation
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic        [Z_W-1:0]  z;
    } pvs_word_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [Z_W-1:0] atan_turn(input int unsigned idx);
        logic [Z_W-1:0] a;
        case (idx)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== design/pvs_cell.sv =====
// One CORDIC micro-rotation cell of the polar vector sum cell row.
// Handles both rotation and vectoring words; uses pvs_pkg.
`default_nettype none

module pvs_cell
    import pvs_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire pvs_word_t in_word,
    output logic           out_valid,
    output pvs_word_t      out_word
);

    localparam logic [Z_W-1:0] ATAN = atan_turn(STEP);

    logic                   valid_reg;
    pvs_word_t              word_reg;
    pvs_word_t              word_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   ccw;

    // Pick direction: rotation drives z to zero, vectoring drives y to zero
    always_comb begin
        dx  = in_word.y >>> STEP;
        dy  = in_word.x >>> STEP;
        ccw = in_word.vec ? in_word.y[XY_W-1] : ~in_word.z[Z_W-1];
        word_next.vec = in_word.vec;
        if (ccw) begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - ATAN;
        end else begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + ATAN;
        end
    end

    // Hand the word to the next cell every cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== design/polar_vector_sum.sv =====
// Polar vector sum: accumulates polar forces and reports the resultant.
// Top level; instantiates a row of pvs_cell CORDIC cells, uses pvs_pkg.
//
// Usage:
//   Input words on s_tvalid/s_tready/s_tdata/s_tlast carry one force each
//   (angle in 65536 units per turn, unsigned magnitude). s_tlast marks the
//   last force of a set; the resultant's length and angle then come out as
//   one word on m_tvalid/m_tready/m_tdata and the running sums clear.
//   Each force passes once through the row of CORDIC_STEPS cells (rotation),
//   then a multiply step and an accumulate step; a new force is taken only
//   once the sequencer is back in idle. Forces beyond MAX_FORCES in one set
//   are dropped. After the last force the sums go through the same cell row
//   in vectoring mode, then scaling and rounding. The cell row, which handles
//   one word at a time, sets the rate. The result sits in an output register,
//   so forces of the next set are taken while it waits; while the receiver
//   stalls, the next result waits in S_OUT and no forces are taken meanwhile.
//   Reset (aresetn low, synchronous) clears sums, force count and valids.
`default_nettype none

module polar_vector_sum
    import pvs_pkg::*;
#(
    parameter int MAX_FORCES   = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] force_angle, [31:16] force_magnitude
    input  wire logic        s_tlast,   // last_force
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // [23:0] sum_magnitude, [39:24] sum_angle
);

    localparam int CNT_W = $clog2(MAX_FORCES + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROT   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_VEC   = 3'd3;
    localparam logic [2:0] S_VWAIT = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]        state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic signed [31:0] x_total_reg, x_total_next;
    logic signed [31:0] y_total_reg, y_total_next;
    logic [15:0]       mag_reg,      mag_next;
    logic [1:0]        quad_reg,     quad_next;
    logic              last_reg,     last_next;
    logic signed [48:0] prod_x_reg,  prod_x_next;
    logic signed [48:0] prod_y_reg,  prod_y_next;
    logic [28:0]       xf_reg,       xf_next;
    logic              sat_reg,      sat_next;
    logic [Z_W-1:0]    zf_reg,       zf_next;
    logic [54:0]       scale_reg,    scale_next;
    logic              m_valid_reg,  m_valid_next;
    logic [39:0]       m_data_reg,   m_data_next;

    // Cell row
    logic              row_valid [0:CORDIC_STEPS];
    pvs_word_t         row_word  [0:CORDIC_STEPS];

    logic              accept;
    logic              room;
    logic signed [31:0] c_sel;
    logic signed [31:0] s_sel;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [18:0] part_x;
    logic signed [18:0] part_y;
    logic signed [48:0] rnd_x;
    logic signed [48:0] rnd_y;
    logic signed [33:0] sum_x;
    logic signed [33:0] sum_y;
    logic signed [XY_W-1:0] vx;
    logic signed [XY_W-1:0] vy;
    logic signed [XY_W-1:0] xfin;
    logic [55:0]       mag_rnd;
    logic [25:0]       mag_q;
    logic [Z_W-1:0]    ang_rnd;
    logic              out_free;

    // Clamp a widened sum to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign room     = (count_reg < CNT_W'(MAX_FORCES));
    assign out_free = ~m_valid_reg | m_tready;

    // Feed the row: a force rotation from idle, or the sums for vectoring
    always_comb begin
        vx = {{(XY_W-36){x_total_reg[31]}}, x_total_reg, 4'b0000};
        vy = {{(XY_W-36){y_total_reg[31]}}, y_total_reg, 4'b0000};
        row_word[0].vec = 1'b0;
        row_word[0].x   = XY_W'(signed'({1'b0, GAIN_Q30}));
        row_word[0].y   = '0;
        row_word[0].z   = {2'b00, s_tdata[13:0], 16'h0000};
        row_valid[0]    = accept & room;
        if (state_reg == S_VEC) begin
            row_word[0].vec = 1'b1;
            if (x_total_reg[31]) begin
                row_word[0].x = -vx;
                row_word[0].y = -vy;
                row_word[0].z = 32'h8000_0000;
            end else begin
                row_word[0].x = vx;
                row_word[0].y = vy;
                row_word[0].z = '0;
            end
            row_valid[0] = (x_total_reg != 32'sd0) || (y_total_reg != 32'sd0);
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        pvs_cell #(
            .STEP (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (row_valid[g]),
            .in_word   (row_word[g]),
            .out_valid (row_valid[g+1]),
            .out_word  (row_word[g+1])
        );
    end

    // Datapath pieces between the row and the sums
    always_comb begin
        cx = row_word[CORDIC_STEPS].x[31:0];
        cy = row_word[CORDIC_STEPS].y[31:0];
        case (quad_reg)
            2'd0:    begin c_sel = cx;  s_sel = cy;  end
            2'd1:    begin c_sel = -cy; s_sel = cx;  end
            2'd2:    begin c_sel = -cx; s_sel = -cy; end
            default: begin c_sel = cy;  s_sel = -cx; end
        endcase
        rnd_x  = prod_x_reg + 49'sd536870912;
        rnd_y  = prod_y_reg + 49'sd536870912;
        part_x = rnd_x[48:30];
        part_y = rnd_y[48:30];
        sum_x  = 34'(x_total_reg) + 34'(part_x);
        sum_y  = 34'(y_total_reg) + 34'(part_y);
        xfin   = row_word[CORDIC_STEPS].x;
        mag_rnd = {1'b0, scale_reg} + 56'd536870912;
        mag_q   = mag_rnd[55:30];
        ang_rnd = zf_reg + 32'h0000_8000;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        x_total_next = x_total_reg;
        y_total_next = y_total_reg;
        mag_next     = mag_reg;
        quad_next    = quad_reg;
        last_next    = last_reg;
        prod_x_next  = prod_x_reg;
        prod_y_next  = prod_y_reg;
        xf_next      = xf_reg;
        sat_next     = sat_reg;
        zf_next      = zf_reg;
        scale_next   = scale_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mag_next  = s_tdata[31:16];
                    quad_next = s_tdata[15:14];
                    last_next = s_tlast;
                    if (room) begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_ROT;
                    end else if (s_tlast) begin
                        state_next = S_VEC;
                    end
                end
            end
            S_ROT: begin
                // Scale the unit vector by the magnitude
                if (row_valid[CORDIC_STEPS]) begin
                    prod_x_next = signed'({1'b0, mag_reg}) * c_sel;
                    prod_y_next = signed'({1'b0, mag_reg}) * s_sel;
                    state_next  = S_ACC;
                end
            end
            S_ACC: begin
                x_total_next = clamp32(sum_x);
                y_total_next = clamp32(sum_y);
                state_next   = last_reg ? S_VEC : S_IDLE;
            end
            S_VEC: begin
                // Zero resultant skips the row and yields zero length and angle
                if (x_total_reg == 32'sd0 && y_total_reg == 32'sd0) begin
                    xf_next    = '0;
                    sat_next   = 1'b0;
                    zf_next    = '0;
                    state_next = S_SCALE;
                end else begin
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT: begin
                if (row_valid[CORDIC_STEPS]) begin
                    zf_next = row_word[CORDIC_STEPS].z;
                    if (xfin[XY_W-1]) begin
                        xf_next  = '0;
                        sat_next = 1'b0;
                    end else begin
                        xf_next  = xfin[28:0];
                        sat_next = |xfin[XY_W-2:29];
                    end
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                scale_next = 55'(xf_reg) * 55'(GAIN_Q26);
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free, then clear the set
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next[39:24] = ang_rnd[31:16];
                    if (sat_reg || mag_q[25:24] != 2'b00) begin
                        m_data_next[23:0] = 24'hFF_FFFF;
                    end else begin
                        m_data_next[23:0] = mag_q[23:0];
                    end
                    x_total_next = '0;
                    y_total_next = '0;
                    count_next   = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            x_total_reg <= '0;
            y_total_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            x_total_reg <= x_total_next;
            y_total_reg <= y_total_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg    <= mag_next;
        quad_reg   <= quad_next;
        last_reg   <= last_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        xf_reg     <= xf_next;
        sat_reg    <= sat_next;
        zf_reg     <= zf_next;
        scale_reg  <= scale_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for polar_vector_sum: streams polar forces and checks each resultant.
// Holds its own fixed-point CORDIC predictor and uses pvs_pkg only through the DUT instance.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS        = 16;
    localparam int SET_LIMIT    = 256;
    localparam int LATENCY      = 2 * STEPS + 5;
    localparam int FORCE_TARGET = 1850;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint GAIN_Q26   = 64'sd40752055;
    localparam longint ROUND_HALF = 64'sd536870912;
    localparam longint SUM_HI     = 64'sd2147483647;
    localparam longint SUM_LO     = -64'sd2147483648;
    localparam longint LEN_HI     = 64'sd16777215;

    localparam logic [15:0] QUARTER = 16'd16384;
    localparam logic [15:0] HALF    = 16'd32768;

    typedef struct packed {
        logic [23:0] magnitude;
        logic [15:0] angle;
    } resultant_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] force_angle, [31:16] force_magnitude
    logic        s_tlast  = 1'b0; // last_force
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [23:0] sum_magnitude, [39:24] sum_angle

    // Predictor state: running sums and forces taken in the open set
    longint      x_sum = 0;
    longint      y_sum = 0;
    int          forces_in_set = 0;
    resultant_t  expected_resultants[$];
    resultant_t  head_result;

    // Stall control for both sides
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold = 0;

    // Run statistics
    int          error_count = 0;
    int          forces_sent = 0;
    int          forces_counted = 0;
    int          forces_dropped = 0;
    int          sets_closed = 0;
    int          results_checked = 0;
    int          zero_results = 0;
    int          clamped_results = 0;
    int          cycle_count = 0;

    polar_vector_sum #(
        .MAX_FORCES   (SET_LIMIT),
        .CORDIC_STEPS (STEPS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // atan(2^-i) in 2^32 units per turn
    function automatic longint arctan_turn(input int i);
        longint a;
        case (i)
            0:  a = 536870912;
            1:  a = 316933406;
            2:  a = 167458907;
            3:  a = 85004756;
            4:  a = 42667331;
            5:  a = 21354465;
            6:  a = 10679838;
            7:  a = 5340245;
            8:  a = 2670163;
            9:  a = 1335087;
            10: a = 667544;
            11: a = 333772;
            12: a = 166886;
            13: a = 83443;
            14: a = 41722;
            15: a = 20861;
            16: a = 10430;
            17: a = 5215;
            18: a = 2608;
            19: a = 1304;
            20: a = 652;
            21: a = 326;
            22: a = 163;
            23: a = 81;
            default: a = 0;
        endcase
        return a;
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > SUM_HI) return SUM_HI;
        if (v < SUM_LO) return SUM_LO;
        return v;
    endfunction

    // Rotate (1/K, 0) by the residual below a quarter turn, then by the quadrant
    function automatic void force_direction(input logic [15:0] ang,
                                            output longint c, output longint s);
        longint x, y, z, dx, dy;
        int     i;
        x = GAIN_Q30;
        y = 0;
        z = longint'(ang[13:0]) <<< 16;
        for (i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn(i);
            end
        end
        case (ang[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // Vector the sums into length and angle
    function automatic resultant_t vector_sums(input longint xs, input longint ys);
        resultant_t  r;
        longint      x, y, dx, dy, len;
        logic [31:0] z, zr;
        int          i;
        r = '0;
        if (xs != 0 || ys != 0) begin
            x = xs * 16;
            y = ys * 16;
            z = '0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + 32'(arctan_turn(i));
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - 32'(arctan_turn(i));
                end
            end
            if (x < 0) x = 0;
            len = (x * GAIN_Q26 + ROUND_HALF) >>> 30;
            if (len > LEN_HI) len = LEN_HI;
            zr = z + 32'h8000;
            r.magnitude = len[23:0];
            r.angle     = zr[31:16];
        end
        return r;
    endfunction

    // Fold one accepted force into the sums; close the set on the last mark
    function automatic void predict_force(input logic [15:0] ang, input logic [15:0] mag,
                                          input logic last);
        longint     c, s, m;
        resultant_t r;
        if (forces_in_set < SET_LIMIT) begin
            force_direction(ang, c, s);
            m = longint'(mag);
            x_sum = clamp_sum(x_sum + ((m * c + ROUND_HALF) >>> 30));
            y_sum = clamp_sum(y_sum + ((m * s + ROUND_HALF) >>> 30));
            forces_in_set++;
            forces_counted++;
        end else begin
            forces_dropped++;
        end
        if (last) begin
            r = vector_sums(x_sum, y_sum);
            if (x_sum == 0 && y_sum == 0) zero_results++;
            if (r.magnitude == 24'hFF_FFFF) clamped_results++;
            expected_resultants.push_back(r);
            x_sum = 0;
            y_sum = 0;
            forces_in_set = 0;
            sets_closed++;
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Send one force word; return once it is accepted
    task automatic send_force(input logic [15:0] ang, input logic [15:0] mag,
                              input logic last);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {mag, ang};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_force(ang, mag, last);
        forces_sent++;
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_resultants.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls on m_tready
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 2) == 0) rx_hold <= pick_gap();
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resultants.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                head_result = expected_resultants.pop_front();
                results_checked++;
                if (m_tdata[23:0] !== head_result.magnitude) begin
                    $error("sum_magnitude: expected %0d, actual %0d",
                           head_result.magnitude, m_tdata[23:0]);
                    error_count++;
                end
                if (m_tdata[39:24] !== head_result.angle) begin
                    $error("sum_angle: expected %0d, actual %0d",
                           head_result.angle, m_tdata[39:24]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("polar_vector_sum verification failed");
        $finish;
    end

    // Single-force sets on each axis, at the field extremes and near quadrant edges
    task automatic test_single_forces();
        send_force(16'd0, 16'd1000, 1'b1);
        send_force(QUARTER, 16'd1000, 1'b1);
        send_force(HALF, 16'd1000, 1'b1);
        send_force(16'd49152, 16'd1000, 1'b1);
        send_force(16'd65535, 16'd65535, 1'b1);
        send_force(16'd8192, 16'd65535, 1'b1);
        send_force(16'd16383, 16'd40000, 1'b1);
        send_force(16'd16385, 16'd1, 1'b1);
        send_force(16'd43690, 16'd65535, 1'b1);
        drain_results();
    endtask

    // Sets whose resultant is exactly zero
    task automatic test_zero_resultant();
        send_force(16'd0, 16'd0, 1'b1);
        send_force(16'd0, 16'd65535, 1'b0);
        send_force(HALF, 16'd65535, 1'b1);
        send_force(16'd21845, 16'd0, 1'b0);
        send_force(16'd54613, 16'd0, 1'b1);
        drain_results();
    endtask

    // Short sets mixing directions, including one landing on an axis
    task automatic test_mixed_sets();
        send_force(16'd0, 16'd65535, 1'b0);
        send_force(QUARTER, 16'd65535, 1'b0);
        send_force(HALF, 16'd300, 1'b1);
        send_force(16'd8192, 16'd5000, 1'b0);
        send_force(16'd57344, 16'd5000, 1'b1);
        send_force(16'd40000, 16'd1, 1'b0);
        send_force(16'd7232, 16'd1, 1'b0);
        send_force(16'd12345, 16'd54321, 1'b1);
        drain_results();
    endtask

    // Sets longer than the force limit; the first one also takes the length near its clamp
    task automatic test_overlong_sets();
        int i;
        tx_idle_on = 1'b0;
        for (i = 0; i < SET_LIMIT + 4; i++)
            send_force(16'd0, 16'd65535, i == SET_LIMIT + 3);
        tx_idle_on = 1'b1;
        for (i = 0; i <= SET_LIMIT; i++)
            send_force(16'($urandom), 16'($urandom), i == SET_LIMIT);
        drain_results();
    endtask

    // One random set; the style picks how angles and magnitudes are drawn
    task automatic send_random_set(input int len);
        int          i, style;
        logic [15:0] ang, mag;
        style = $urandom_range(0, 9);
        i = 0;
        while (i < len) begin
            ang = 16'($urandom);
            mag = 16'($urandom);
            case (style)
                0: ang = 16'($urandom_range(0, 3)) * QUARTER;
                1: mag = 16'($urandom_range(0, 15));
                2: mag = 16'd65535 - 16'($urandom_range(0, 3));
                3: ang = 16'($urandom_range(0, 3)) * QUARTER + 16'($urandom_range(0, 2)) - 16'd1;
                default: ;
            endcase
            // Occasionally pair a force with its exact opposite
            if (style == 4 && i + 1 < len) begin
                send_force(ang, mag, 1'b0);
                i++;
                ang = ang + HALF;
            end
            send_force(ang, mag, i == len - 1);
            i++;
        end
    endtask

    // Random sets until the force budget is used, with idle modes varied per set
    task automatic test_random_sets();
        int r, len;
        while (forces_counted < FORCE_TARGET) begin
            tx_idle_on = ($urandom_range(0, 7) != 0);
            rx_idle_on = ($urandom_range(0, 7) != 0);
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 6);
            else if (r < 96) len = $urandom_range(7, 40);
            else len = $urandom_range(41, 120);
            send_random_set(len);
            if ($urandom_range(0, 19) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_forces();
        test_zero_resultant();
        test_mixed_sets();
        test_overlong_sets();
        test_random_sets();

        // Let any stray result show up before closing
        repeat (LATENCY + 20) @(posedge aclk);
        if (expected_resultants.size() != 0) begin
            $error("%0d expected results never arrived", expected_resultants.size());
            error_count++;
        end

        $display("Sent %0d forces in %0d sets (%0d past the set limit), checked %0d results.",
                 forces_sent, sets_closed, forces_dropped, results_checked);
        $display("Zero resultants: %0d, clamped lengths: %0d, cycles: %0d.",
                 zero_results, clamped_results, cycle_count);
        if (error_count == 0) begin
            $display("polar_vector_sum verification clean");
        end else begin
            $display("polar_vector_sum verification failed");
        end
        $finish;
    end

endmodule

// ===== polar_vector_sum.f =====
design/pvs_pkg.sv
design/pvs_cell.sv
design/polar_vector_sum.sv
bench/tb_top.sv
